/* src/ctb_pkg.sv */
// shared types and constants for the cursor text buffer
`default_nettype none
package ctb_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CHAR_W   = 8;
	localparam int DIST_W   = 16;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		CMD_TYPE  = 2'd0,
		CMD_MOVE  = 2'd1,
		CMD_BACK  = 2'd2,
		CMD_PRINT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_PRINT_RD,
		ST_PRINT_LD,
		ST_PRINT_EMPTY
	} state_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [CHAR_W-1:0]        ch;
		logic signed [DIST_W-1:0] distance;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              has_char;
		logic              last;
		logic              overflowed;
	} rsp_t;

endpackage
`default_nettype wire

/* src/ctb_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none
module ctb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/cursor_text_buffer.sv */
// gap-buffer line editor: one text memory, cursor counts and print sequencer
// Type and backspace complete in the idle state when accepted. A move of n characters
// does one memory read and one write per step, and stops early at either end of the
// text. A print reads each character in a read state and delivers it from a load state
// that waits while an unaccepted beat is held, and an empty buffer prints a single beat
// with has_char low. A new command is taken only when the previous one has finished;
// a finished result may still wait at the output while the next command is accepted.
`default_nettype none
module cursor_text_buffer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire ctb_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output ctb_pkg::rsp_t      rsp
);

	ctb_pkg::state_t state_q, state_d;
	logic [ctb_pkg::CNT_W-1:0]  left_q, left_d, right_q, right_d, k_q, k_d;
	logic [ctb_pkg::DIST_W-1:0] remain_q, remain_d;
	logic dir_q, dir_d, ovf_q, ovf_d;
	logic pend_s1, pend_d;
	logic [ctb_pkg::ADDR_W-1:0] waddr_s1, waddr_d;
	logic rsp_valid_q, rsp_valid_d;
	ctb_pkg::rsp_t rsp_q, rsp_d;

	logic ram_we, ram_re;
	logic [ctb_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ctb_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

	logic [ctb_pkg::CNT_W-1:0] total, gap, src_r, dst_l, prt_hi, k_inc;
	logic slot_free, step_ok;

	ctb_ram #(
		.WIDTH(ctb_pkg::CHAR_W),
		.DEPTH(ctb_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign total     = left_q + right_q;
	assign gap       = ctb_pkg::CAP_CNT - total;
	assign src_r     = ctb_pkg::CAP_CNT - right_q;
	assign dst_l     = ctb_pkg::CAP_CNT - right_q - 1'b1;
	assign prt_hi    = k_q + gap;
	assign k_inc     = k_q + 1'b1;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign step_ok   = (remain_q != '0) && (dir_q ? (left_q != '0) : (right_q != '0));

	assign req_ready = (state_q == ctb_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctb_pkg::ST_IDLE;
			left_q      <= '0;
			right_q     <= '0;
			k_q         <= '0;
			remain_q    <= '0;
			dir_q       <= 1'b0;
			ovf_q       <= 1'b0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			left_q      <= left_d;
			right_q     <= right_d;
			k_q         <= k_d;
			remain_q    <= remain_d;
			dir_q       <= dir_d;
			ovf_q       <= ovf_d;
			pend_s1     <= pend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= waddr_d;
		rsp_q    <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		left_d      = left_q;
		right_d     = right_q;
		k_d         = k_q;
		remain_d    = remain_q;
		dir_d       = dir_q;
		ovf_d       = ovf_q;
		pend_d      = 1'b0;
		waddr_d     = waddr_s1;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		rsp_d       = rsp_q;
		ram_we      = 1'b0;
		ram_waddr   = waddr_s1;
		ram_wdata   = ram_rdata;
		ram_re      = 1'b0;
		ram_raddr   = k_q[ctb_pkg::ADDR_W-1:0];

		unique case (state_q)
			ctb_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req.cmd)
						ctb_pkg::CMD_TYPE: begin
							if (total >= ctb_pkg::CAP_CNT) begin
								ovf_d = 1'b1;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = left_q[ctb_pkg::ADDR_W-1:0];
								ram_wdata = req.ch;
								left_d    = left_q + 1'b1;
							end
						end
						ctb_pkg::CMD_MOVE: begin
							dir_d    = req.distance[ctb_pkg::DIST_W-1];
							remain_d = req.distance[ctb_pkg::DIST_W-1] ?
								$unsigned(-req.distance) : $unsigned(req.distance);
							state_d  = ctb_pkg::ST_MOVE;
						end
						ctb_pkg::CMD_BACK: begin
							if (left_q != '0) begin
								left_d = left_q - 1'b1;
							end
						end
						ctb_pkg::CMD_PRINT: begin
							k_d     = '0;
							state_d = (total == '0) ? ctb_pkg::ST_PRINT_EMPTY :
								ctb_pkg::ST_PRINT_RD;
						end
						default: ;
					endcase
				end
			end
			ctb_pkg::ST_MOVE: begin
				// write back the character read on the previous step
				ram_we = pend_s1;
				if (step_ok) begin
					ram_re   = 1'b1;
					pend_d   = 1'b1;
					remain_d = remain_q - 1'b1;
					if (dir_q) begin
						ram_raddr = left_d[ctb_pkg::ADDR_W-1:0];
						left_d    = left_q - 1'b1;
						ram_raddr = left_d[ctb_pkg::ADDR_W-1:0];
						waddr_d   = dst_l[ctb_pkg::ADDR_W-1:0];
						right_d   = right_q + 1'b1;
					end else begin
						ram_raddr = src_r[ctb_pkg::ADDR_W-1:0];
						waddr_d   = left_q[ctb_pkg::ADDR_W-1:0];
						left_d    = left_q + 1'b1;
						right_d   = right_q - 1'b1;
					end
				end else begin
					state_d = ctb_pkg::ST_IDLE;
				end
			end
			ctb_pkg::ST_PRINT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = (k_q < left_q) ? k_q[ctb_pkg::ADDR_W-1:0] :
					prt_hi[ctb_pkg::ADDR_W-1:0];
				state_d   = ctb_pkg::ST_PRINT_LD;
			end
			ctb_pkg::ST_PRINT_LD: begin
				if (slot_free) begin
					rsp_valid_d      = 1'b1;
					rsp_d.out_char   = ram_rdata;
					rsp_d.has_char   = 1'b1;
					rsp_d.last       = (k_inc == total);
					rsp_d.overflowed = ovf_q;
					k_d              = k_inc;
					state_d = (k_inc == total) ? ctb_pkg::ST_IDLE : ctb_pkg::ST_PRINT_RD;
				end
			end
			ctb_pkg::ST_PRINT_EMPTY: begin
				if (slot_free) begin
					rsp_valid_d      = 1'b1;
					rsp_d.out_char   = '0;
					rsp_d.has_char   = 1'b0;
					rsp_d.last       = 1'b1;
					rsp_d.overflowed = ovf_q;
					state_d          = ctb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ctb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/ctb_checker.sv */
// port-level checks for the cursor text buffer, bound to the top level
`default_nettype none
module ctb_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire ctb_pkg::rsp_t rsp
);

	// stalled beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

	// the empty-buffer beat is alone and blank
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_char |-> rsp.last && (rsp.out_char == '0))
		else $error("empty print beat malformed");

	// mid-print no new command is taken
	a_print_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> !req_ready)
		else $error("command accepted during print");

	// overflow flag never clears between beats
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.overflowed ##1 rsp_valid |-> rsp.overflowed)
		else $error("overflow flag cleared");

endmodule

bind cursor_text_buffer ctb_checker u_ctb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
`default_nettype wire

/* bench/tb.sv */
// self-checking testbench for the cursor text buffer against a shadow gap buffer
`timescale 1ns / 1ps
module tb;

	typedef logic [ctb_pkg::CHAR_W-1:0] char_t;
	typedef logic [ctb_pkg::DIST_W-1:0] dist_t;

	typedef struct {
		ctb_pkg::req_t req;
		bit            drain;
		bit            quiet;
	} edit_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ctb_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ctb_pkg::rsp_t rsp;

	edit_item_t    edit_q[$];
	ctb_pkg::rsp_t print_q[$];

	char_t shadow_text [ctb_pkg::CAPACITY];
	int  shadow_left;
	int  shadow_right;
	bit  shadow_ovf;

	int  edits_total;
	int  edits_taken;
	int  fail_count;
	int  quiet_left;
	int  send_gap;
	int  recv_gap;
	bit  recv_steady;

	cursor_text_buffer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void push_beat(char_t c, logic has, logic fin);
		ctb_pkg::rsp_t beat;
		beat.out_char   = c;
		beat.has_char   = has;
		beat.last       = fin;
		beat.overflowed = shadow_ovf;
		print_q.push_back(beat);
	endfunction

	// shadow gap buffer, updated once per accepted command
	function automatic void apply_edit(ctb_pkg::req_t r);
		int steps;
		int total;
		int k;
		case (r.cmd)
			ctb_pkg::CMD_TYPE: begin
				if (shadow_left + shadow_right >= ctb_pkg::CAPACITY) begin
					shadow_ovf = 1'b1;
				end else begin
					shadow_text[shadow_left] = r.ch;
					shadow_left++;
				end
			end
			ctb_pkg::CMD_MOVE: begin
				if (!r.distance[ctb_pkg::DIST_W-1]) begin
					steps = int'(r.distance);
					while (steps > 0 && shadow_right > 0) begin
						shadow_text[shadow_left] =
							shadow_text[ctb_pkg::CAPACITY - shadow_right];
						shadow_left++;
						shadow_right--;
						steps--;
					end
				end else begin
					steps = -int'(r.distance);
					while (steps > 0 && shadow_left > 0) begin
						shadow_left--;
						shadow_right++;
						shadow_text[ctb_pkg::CAPACITY - shadow_right] =
							shadow_text[shadow_left];
						steps--;
					end
				end
			end
			ctb_pkg::CMD_BACK: begin
				if (shadow_left > 0) shadow_left--;
			end
			ctb_pkg::CMD_PRINT: begin
				total = shadow_left + shadow_right;
				k = 0;
				if (total == 0) begin
					push_beat('0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < shadow_left; i++) begin
						k++;
						push_beat(shadow_text[i], 1'b1, k == total);
					end
					for (int i = ctb_pkg::CAPACITY - shadow_right; i < ctb_pkg::CAPACITY;
						i++) begin
						k++;
						push_beat(shadow_text[i], 1'b1, k == total);
					end
				end
			end
		endcase
	endfunction

	task automatic add_edit(ctb_pkg::cmd_t c, char_t ch, dist_t d, bit drain);
		edit_item_t item;
		item.req.cmd      = c;
		item.req.ch       = ch;
		item.req.distance = d;
		item.drain        = drain;
		item.quiet        = quiet_left > 0;
		if (quiet_left > 0) quiet_left--;
		edit_q.push_back(item);
		edits_total++;
	endtask

	function automatic dist_t pick_distance();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return dist_t'($urandom_range(0, 16) - 8);
		if (r < 80) return dist_t'($urandom_range(0, 65535));
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0040;
			default: return 16'hFFC0;
		endcase
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : driver
		edit_item_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				apply_edit(req);
				edits_taken++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (edit_q.size() > 0 &&
					!(edit_q[0].drain && print_q.size() > 0)) begin
					nxt = edit_q.pop_front();
					req <= nxt.req;
					req_valid <= 1'b1;
					send_gap = nxt.quiet ? 0 : pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : monitor
		ctb_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_gap = 0;
			recv_steady = 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (print_q.size() == 0) begin
					$error("print beat with nothing expected: char %0h", rsp.out_char);
					fail_count++;
				end else begin
					want = print_q.pop_front();
					if (rsp.out_char !== want.out_char) begin
						$error("out_char expected %0h got %0h", want.out_char, rsp.out_char);
						fail_count++;
					end
					if (rsp.has_char !== want.has_char) begin
						$error("has_char expected %0b got %0b", want.has_char, rsp.has_char);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$error("last expected %0b got %0b", want.last, rsp.last);
						fail_count++;
					end
					if (rsp.overflowed !== want.overflowed) begin
						$error("overflowed expected %0b got %0b", want.overflowed,
							rsp.overflowed);
						fail_count++;
					end
				end
				if ($urandom_range(0, 99) == 0) recv_steady = !recv_steady;
				recv_gap = recv_steady ? 0 : pick_gap();
			end else if (recv_gap > 0) begin
				recv_gap--;
			end else if (!rsp_valid && !recv_steady && $urandom_range(0, 15) == 0) begin
				recv_gap = pick_gap();
			end
			rsp_ready <= (recv_gap == 0);
		end
	end

	initial begin : stimulus
		int added;
		int r;
		fail_count = 0;
		edits_total = 0;
		edits_taken = 0;
		quiet_left = 0;
		shadow_left = 0;
		shadow_right = 0;
		shadow_ovf = 1'b0;

		// directed: empty print, edges of the cursor, extreme bytes and distances
		add_edit(ctb_pkg::CMD_PRINT, 8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_BACK,  8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'hFFFF, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'h0001, 1'b0);
		add_edit(ctb_pkg::CMD_TYPE,  8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_TYPE,  8'hFF, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_TYPE,  8'h41, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_PRINT, 8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'h8000, 1'b0);
		add_edit(ctb_pkg::CMD_BACK,  8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_TYPE,  8'h55, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'h7FFF, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'hFFFF, 1'b0);
		add_edit(ctb_pkg::CMD_BACK,  8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'h0002, 1'b0);
		add_edit(ctb_pkg::CMD_TYPE,  8'hAA, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_PRINT, 8'h00, 16'h0000, 1'b0);
		add_edit(ctb_pkg::CMD_MOVE,  8'h00, 16'hFFFE, 1'b0);
		add_edit(ctb_pkg::CMD_TYPE,  8'h5A, 16'hFFFF, 1'b0);
		add_edit(ctb_pkg::CMD_PRINT, 8'hFF, 16'hFFFF, 1'b0);

		// random edit sessions with occasional fill-up and wipe-out runs
		added = 0;
		while (added < 300) begin
			if (quiet_left == 0 && $urandom_range(0, 19) == 0)
				quiet_left = $urandom_range(10, 30);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				add_edit(ctb_pkg::CMD_TYPE, 8'($urandom_range(0, 255)),
					dist_t'($urandom_range(0, 65535)),
					added == 0 || $urandom_range(0, 19) == 0);
				added++;
			end else if (r < 65) begin
				add_edit(ctb_pkg::CMD_MOVE, 8'($urandom_range(0, 255)), pick_distance(), 1'b0);
				added++;
			end else if (r < 80) begin
				add_edit(ctb_pkg::CMD_BACK, 8'($urandom_range(0, 255)),
					dist_t'($urandom_range(0, 65535)), 1'b0);
				added++;
			end else if (r < 92) begin
				add_edit(ctb_pkg::CMD_PRINT, 8'($urandom_range(0, 255)),
					dist_t'($urandom_range(0, 65535)), $urandom_range(0, 9) == 0);
				added++;
			end else if (r < 96) begin
				if ($urandom_range(0, 1))
					add_edit(ctb_pkg::CMD_MOVE, 8'h00, pick_distance(), 1'b0);
				repeat (ctb_pkg::CAPACITY + 6)
					add_edit(ctb_pkg::CMD_TYPE, 8'($urandom_range(0, 255)), 16'h0000, 1'b0);
				add_edit(ctb_pkg::CMD_PRINT, 8'h00, 16'h0000, 1'b0);
				add_edit(ctb_pkg::CMD_MOVE, 8'h00,
					dist_t'(-$urandom_range(1, ctb_pkg::CAPACITY)), 1'b0);
				add_edit(ctb_pkg::CMD_PRINT, 8'h00, 16'h0000, 1'b0);
				added += ctb_pkg::CAPACITY + 10;
			end else begin
				add_edit(ctb_pkg::CMD_MOVE, 8'h00, 16'h7FFF, 1'b0);
				repeat (ctb_pkg::CAPACITY)
					add_edit(ctb_pkg::CMD_BACK, 8'($urandom_range(0, 255)), 16'h0000, 1'b0);
				add_edit(ctb_pkg::CMD_PRINT, 8'h00, 16'h0000, 1'b0);
				added += ctb_pkg::CAPACITY + 2;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (edits_taken < edits_total) @(negedge clk);
		while (print_q.size() > 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (print_q.size() > 0) begin
			$error("%0d print beats never arrived", print_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
